@@ hdl/fcw_pkg.sv @@
// Shared types and constants for the FAT12 cluster chain walker.
`timescale 1ns / 1ps

package fcw_pkg;

  // Allocation table image
  localparam int TABLE_BYTES = 8192;
  localparam int TABLE_AW    = $clog2(TABLE_BYTES);

  // Run limit and field widths
  localparam int MAX_RUN  = 64;
  localparam int RUN_W    = 6;
  localparam int ENTRY_W  = 12;
  localparam logic [RUN_W-1:0] RUN_LAST = RUN_W'(MAX_RUN - 1);

  // Request codes
  localparam logic REQ_LOAD = 1'b0;
  localparam logic REQ_WALK = 1'b1;

  // Configuration register map (word index)
  typedef enum logic [1:0] {
    REG_DATA_START   = 2'd0,
    REG_SPC          = 2'd1,
    REG_SECTOR_BYTES = 2'd2,
    REG_END_MARKER   = 2'd3
  } cfg_reg_t;

  // Register reset values
  localparam logic [31:0]        RST_DATA_START   = 32'd0;
  localparam logic [7:0]         RST_SPC          = 8'd1;
  localparam logic [12:0]        RST_SECTOR_BYTES = 13'd512;
  localparam logic [ENTRY_W-1:0] RST_END_MARKER   = 12'hFFF;

  // Request to the shared multiply-add unit: q = a * b + c (mod 2^32)
  typedef struct packed {
    logic        en;
    logic [31:0] a;
    logic [31:0] b;
    logic [31:0] c;
  } mul_req_t;

endpackage

@@ hdl/fcw_ram.sv @@
// Generic single-port RAM with registered read.
`timescale 1ns / 1ps

module fcw_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] addr,
  input  logic [WIDTH-1:0]         wdata,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // write or read, one access a cycle
  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    rdata <= mem[addr];
  end

endmodule

@@ hdl/fcw_mac.sv @@
// Shared 32-bit multiply-add unit with registered result.
`timescale 1ns / 1ps

module fcw_mac
  import fcw_pkg::*;
(
  input  logic        clk,
  input  mul_req_t    req,
  output logic [31:0] q
);

  logic [31:0] prod;

  // product truncates to 32 bits, as does the sum
  assign prod = req.a * req.b;

  always_ff @(posedge clk) begin
    if (req.en) begin
      q <= prod + req.c;
    end
  end

endmodule

@@ hdl/fat12_cluster_chain_walker_unit.sv @@
// Top level: FAT12 cluster chain walker with table RAM, sequencer and APB registers.
//
//  channel   | handshake            | payload
//  ----------+----------------------+----------------------------------------------
//  request   | start, busy          | req_type, table_address, table_byte,
//            |                      | start_cluster
//  result    | result_valid         | link_id, sector_index, byte_offset,
//            |                      | run_index, next_cluster, last, chain_empty,
//            |                      | bad_cluster, truncated
//  config    | psel, penable, pready| pwrite, paddr, pwdata, prdata
//
// A load writes its table byte without raising busy. For each cluster a walk
// passes S_CHECK (table low byte, first multiply), S_LO (high byte, second
// multiply on the shared unit) and S_HI (result), up to 64 clusters a run. An
// empty chain gives its item in the cycle after acceptance, busy staying low;
// a bad id ends the run in the cycle after it is checked. rst is synchronous
// and clears the sequencer, the result strobe and the configuration registers;
// the table is undefined until loaded. The receiver cannot hold results off.
`timescale 1ns / 1ps

module fat12_cluster_chain_walker_unit
  import fcw_pkg::*;
(
  input  logic                clk,
  input  logic                rst,
  // request channel
  input  logic                start,
  output logic                busy,
  input  logic                req_type,
  input  logic [TABLE_AW-1:0] table_address,
  input  logic [7:0]          table_byte,
  input  logic [ENTRY_W-1:0]  start_cluster,
  // result channel
  output logic                result_valid,
  output logic [ENTRY_W-1:0]  link_id,
  output logic [31:0]         sector_index,
  output logic [31:0]         byte_offset,
  output logic [RUN_W-1:0]    run_index,
  output logic [ENTRY_W-1:0]  next_cluster,
  output logic                last,
  output logic                chain_empty,
  output logic                bad_cluster,
  output logic                truncated,
  // configuration port
  input  logic                psel,
  input  logic                penable,
  input  logic                pwrite,
  input  logic [3:0]          paddr,
  input  logic [31:0]         pwdata,
  output logic [31:0]         prdata,
  output logic                pready
);

  typedef enum logic [1:0] {
    S_IDLE,
    S_CHECK,
    S_LO,
    S_HI
  } state_t;

  state_t              state;
  logic [ENTRY_W-1:0]  cur;
  logic [RUN_W-1:0]    idx;
  logic [7:0]          lo_byte;
  logic [31:0]         sec_q;

  logic [31:0]         data_start_sector;
  logic [7:0]          clus_sectors;
  logic [12:0]         sector_bytes;
  logic [ENTRY_W-1:0]  end_marker;

  logic                ram_we;
  logic [TABLE_AW-1:0] ram_addr;
  logic [7:0]          ram_rdata;
  logic [TABLE_AW-1:0] pos;
  logic [ENTRY_W-1:0]  nxt;
  mul_req_t            mreq;
  logic [31:0]         mul_q;
  logic                cfg_wr;
  cfg_reg_t            cfg_sel;

  // table image
  fcw_ram #(
    .WIDTH (8),
    .DEPTH (TABLE_BYTES)
  ) u_table (
    .clk   (clk),
    .we    (ram_we),
    .addr  (ram_addr),
    .wdata (table_byte),
    .rdata (ram_rdata)
  );

  // shared multiply-add: sector first, then byte offset
  fcw_mac u_mac (
    .clk (clk),
    .req (mreq),
    .q   (mul_q)
  );

  assign busy   = (state != S_IDLE);
  assign pready = 1'b1;

  // entry position: id + id/2
  assign pos = TABLE_AW'(cur) + TABLE_AW'(cur >> 1);

  // odd ids take the upper 12 bits of the word, even ids the lower
  assign nxt = cur[0] ? {ram_rdata, lo_byte[7:4]} : {ram_rdata[3:0], lo_byte};

  // table address and multiply requests per step
  always_comb begin
    ram_we   = 1'b0;
    ram_addr = table_address;
    mreq     = '0;
    unique case (state)
      S_IDLE: begin
        ram_we = start && (req_type == REQ_LOAD);
      end
      S_CHECK: begin
        ram_addr = pos;
        mreq.en  = 1'b1;
        mreq.a   = 32'(cur) - 32'd2;
        mreq.b   = 32'(clus_sectors);
        mreq.c   = data_start_sector;
      end
      S_LO: begin
        ram_addr = pos + TABLE_AW'(1);
        mreq.en  = 1'b1;
        mreq.a   = mul_q;
        mreq.b   = 32'(sector_bytes);
        mreq.c   = 32'd0;
      end
      S_HI: begin
      end
      default: begin
      end
    endcase
  end

  // sequencer and result registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= S_IDLE;
      result_valid <= 1'b0;
    end else begin
      result_valid <= 1'b0;
      unique case (state)
        S_IDLE: begin
          if (start && (req_type == REQ_WALK)) begin
            if (start_cluster == end_marker) begin
              result_valid <= 1'b1;
              link_id      <= '0;
              sector_index <= '0;
              byte_offset  <= '0;
              run_index    <= '0;
              next_cluster <= '0;
              last         <= 1'b1;
              chain_empty  <= 1'b1;
              bad_cluster  <= 1'b0;
              truncated    <= 1'b0;
            end else begin
              cur   <= start_cluster;
              idx   <= '0;
              state <= S_CHECK;
            end
          end
        end
        S_CHECK: begin
          if (cur < ENTRY_W'(2)) begin
            result_valid <= 1'b1;
            link_id      <= cur;
            sector_index <= '0;
            byte_offset  <= '0;
            run_index    <= idx;
            next_cluster <= '0;
            last         <= 1'b1;
            chain_empty  <= 1'b0;
            bad_cluster  <= 1'b1;
            truncated    <= 1'b0;
            state        <= S_IDLE;
          end else begin
            state <= S_LO;
          end
        end
        S_LO: begin
          lo_byte <= ram_rdata;
          sec_q   <= mul_q;
          state   <= S_HI;
        end
        S_HI: begin
          result_valid <= 1'b1;
          link_id      <= cur;
          sector_index <= sec_q;
          byte_offset  <= mul_q;
          run_index    <= idx;
          next_cluster <= nxt;
          chain_empty  <= 1'b0;
          bad_cluster  <= 1'b0;
          if (nxt == end_marker) begin
            last      <= 1'b1;
            truncated <= 1'b0;
            state     <= S_IDLE;
          end else if (idx == RUN_LAST) begin
            last      <= 1'b1;
            truncated <= 1'b1;
            state     <= S_IDLE;
          end else begin
            last      <= 1'b0;
            truncated <= 1'b0;
            cur       <= nxt;
            idx       <= idx + RUN_W'(1);
            state     <= S_CHECK;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  // configuration registers
  assign cfg_wr  = psel && penable && pwrite && pready;
  assign cfg_sel = cfg_reg_t'(paddr[3:2]);

  always_ff @(posedge clk) begin
    if (rst) begin
      data_start_sector <= RST_DATA_START;
      clus_sectors      <= RST_SPC;
      sector_bytes      <= RST_SECTOR_BYTES;
      end_marker        <= RST_END_MARKER;
    end else if (cfg_wr) begin
      unique case (cfg_sel)
        REG_DATA_START:   data_start_sector <= pwdata;
        REG_SPC:          clus_sectors      <= pwdata[7:0];
        REG_SECTOR_BYTES: sector_bytes      <= pwdata[12:0];
        REG_END_MARKER:   end_marker        <= pwdata[ENTRY_W-1:0];
        default: begin
        end
      endcase
    end
  end

  // register read-back
  always_comb begin
    unique case (cfg_sel)
      REG_DATA_START:   prdata = data_start_sector;
      REG_SPC:          prdata = 32'(clus_sectors);
      REG_SECTOR_BYTES: prdata = 32'(sector_bytes);
      REG_END_MARKER:   prdata = 32'(end_marker);
      default:          prdata = '0;
    endcase
  end

  // checks
  a_bad_ends_run: assert property (@(posedge clk) disable iff (rst)
    (result_valid && bad_cluster) |-> last)
    else $error("bad cluster result not marked last");

  a_trunc_at_limit: assert property (@(posedge clk) disable iff (rst)
    (result_valid && truncated) |-> (last && run_index == RUN_LAST))
    else $error("truncation away from run limit");

  a_empty_no_id: assert property (@(posedge clk) disable iff (rst)
    (result_valid && chain_empty) |-> (link_id == '0 && last && !busy))
    else $error("empty chain result malformed");

  a_walk_goes_busy: assert property (@(posedge clk) disable iff (rst)
    (start && !busy && req_type == REQ_WALK && start_cluster != end_marker)
      |=> (busy && !result_valid))
    else $error("walk did not start");

endmodule

@@ dv/tb.sv @@
// Self-checking testbench for the FAT12 cluster chain walker: table loads, chain walks, geometry.
`timescale 1ns / 1ps

module tb;
  import fcw_pkg::*;

  localparam int WATCHDOG_CYCLES = 2000;
  localparam int QUIET_CYCLES    = 16;

  // One chain element as it leaves the block
  typedef struct packed {
    logic [ENTRY_W-1:0] link_id;
    logic [31:0]        sector_index;
    logic [31:0]        byte_offset;
    logic [RUN_W-1:0]   run_index;
    logic [ENTRY_W-1:0] next_cluster;
    logic               last;
    logic               chain_empty;
    logic               bad_cluster;
    logic               truncated;
  } chain_link_t;

  // Directed stimulus row; link is only used where fixed is set
  typedef struct packed {
    logic               req;
    logic [12:0]        addr;
    logic [7:0]         data;
    logic [ENTRY_W-1:0] first;
    logic               fixed;
    chain_link_t        link;
  } dir_row_t;

  localparam chain_link_t NO_LINK = '0;
  localparam chain_link_t LINK_EMPTY = '{link_id: 12'd0, sector_index: 32'd0,
    byte_offset: 32'd0, run_index: 6'd0, next_cluster: 12'd0, last: 1'b1,
    chain_empty: 1'b1, bad_cluster: 1'b0, truncated: 1'b0};
  localparam chain_link_t LINK_BAD0 = '{link_id: 12'd0, sector_index: 32'd0,
    byte_offset: 32'd0, run_index: 6'd0, next_cluster: 12'd0, last: 1'b1,
    chain_empty: 1'b0, bad_cluster: 1'b1, truncated: 1'b0};
  localparam chain_link_t LINK_BAD1 = '{link_id: 12'd1, sector_index: 32'd0,
    byte_offset: 32'd0, run_index: 6'd0, next_cluster: 12'd0, last: 1'b1,
    chain_empty: 1'b0, bad_cluster: 1'b1, truncated: 1'b0};

  // Reset geometry: empty chain, bad ids, short chains, a bad stop after a good
  // cluster, the top of the table, and a two-cluster loop that hits the run limit
  localparam dir_row_t DIRECTED [21] = '{
    '{REQ_WALK, 13'd0,    8'h00, RST_END_MARKER, 1'b1, LINK_EMPTY},
    '{REQ_WALK, 13'd0,    8'h00, 12'd0,          1'b1, LINK_BAD0},
    '{REQ_WALK, 13'd0,    8'h00, 12'd1,          1'b1, LINK_BAD1},
    '{REQ_LOAD, 13'd3,    8'h03, 12'd0,          1'b0, NO_LINK},
    '{REQ_LOAD, 13'd4,    8'hF0, 12'd0,          1'b0, NO_LINK},
    '{REQ_LOAD, 13'd5,    8'hFF, 12'd0,          1'b0, NO_LINK},
    '{REQ_WALK, 13'd0,    8'h00, 12'd2,          1'b0, NO_LINK},
    '{REQ_WALK, 13'd0,    8'h00, 12'd3,          1'b0, NO_LINK},
    '{REQ_LOAD, 13'd6,    8'h01, 12'd0,          1'b0, NO_LINK},
    '{REQ_LOAD, 13'd7,    8'h00, 12'd0,          1'b0, NO_LINK},
    '{REQ_WALK, 13'd0,    8'h00, 12'd4,          1'b0, NO_LINK},
    '{REQ_LOAD, 13'd6141, 8'h02, 12'd0,          1'b0, NO_LINK},
    '{REQ_LOAD, 13'd6142, 8'hF0, 12'd0,          1'b0, NO_LINK},
    '{REQ_LOAD, 13'd6143, 8'hFF, 12'd0,          1'b0, NO_LINK},
    '{REQ_WALK, 13'd0,    8'h00, 12'd4094,       1'b0, NO_LINK},
    '{REQ_LOAD, 13'd12,   8'h09, 12'd0,          1'b0, NO_LINK},
    '{REQ_LOAD, 13'd13,   8'h80, 12'd0,          1'b0, NO_LINK},
    '{REQ_LOAD, 13'd14,   8'h00, 12'd0,          1'b0, NO_LINK},
    '{REQ_WALK, 13'd0,    8'h00, 12'd8,          1'b0, NO_LINK},
    '{REQ_LOAD, 13'd8191, 8'hFF, 12'hFFF,        1'b0, NO_LINK},
    '{REQ_LOAD, 13'd0,    8'h00, 12'd0,          1'b0, NO_LINK}
  };

  logic                clk = 1'b0;
  logic                rst = 1'b1;
  logic                start = 1'b0;
  logic                busy;
  logic                req_type = 1'b0;
  logic [TABLE_AW-1:0] table_address = '0;
  logic [7:0]          table_byte = '0;
  logic [ENTRY_W-1:0]  start_cluster = '0;
  logic                result_valid;
  logic [ENTRY_W-1:0]  link_id;
  logic [31:0]         sector_index;
  logic [31:0]         byte_offset;
  logic [RUN_W-1:0]    run_index;
  logic [ENTRY_W-1:0]  next_cluster;
  logic                last;
  logic                chain_empty;
  logic                bad_cluster;
  logic                truncated;
  logic                psel = 1'b0;
  logic                penable = 1'b0;
  logic                pwrite = 1'b0;
  logic [3:0]          paddr = '0;
  logic [31:0]         pwdata = '0;
  logic [31:0]         prdata;
  logic                pready;

  fat12_cluster_chain_walker_unit uut (.*);

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // Predictor state: table image and geometry
  logic [7:0]         tbl_image   [TABLE_BYTES];
  bit                 tbl_written [TABLE_BYTES];
  logic [31:0]        cfg_data_start = RST_DATA_START;
  logic [7:0]         cfg_spc        = RST_SPC;
  logic [12:0]        cfg_sector_bytes = RST_SECTOR_BYTES;
  logic [ENTRY_W-1:0] cfg_end_marker = RST_END_MARKER;

  chain_link_t        walk_links [MAX_RUN];
  int                 walk_len;
  bit                 walk_mapped;

  chain_link_t        pending_links [$];
  logic [ENTRY_W-1:0] known_ids [$];

  int idle_pct = 10;
  int items_sent = 0;
  int walks_sent = 0;
  int settings_used = 1;
  int results_seen = 0;
  int trunc_seen = 0;
  int bad_seen = 0;
  int empty_seen = 0;
  int fail_count = 0;
  int stall_cycles = 0;

  // Follow the chain from first; walk_mapped drops if any entry byte was never loaded
  task automatic trace_chain(input logic [ENTRY_W-1:0] first);
    logic [ENTRY_W-1:0] cur;
    logic [ENTRY_W-1:0] nxt;
    logic [15:0]        word;
    logic [31:0]        pos;
    logic [31:0]        sec;
    chain_link_t        lk;
    int                 k;
    bit                 done;
    walk_len = 0;
    walk_mapped = 1'b1;
    cur = first;
    done = 1'b0;
    if (first == cfg_end_marker) begin
      walk_links[0] = LINK_EMPTY;
      walk_len = 1;
    end else begin
      for (k = 0; k < MAX_RUN && !done; k++) begin
        lk = '0;
        lk.link_id = cur;
        lk.run_index = RUN_W'(k);
        if (cur < 12'd2) begin
          lk.last = 1'b1;
          lk.bad_cluster = 1'b1;
          done = 1'b1;
        end else begin
          pos = {20'd0, cur} + {21'd0, cur[11:1]};
          if (!tbl_written[pos] || !tbl_written[pos + 1]) walk_mapped = 1'b0;
          word = {tbl_image[pos + 1], tbl_image[pos]};
          nxt = cur[0] ? word[15:4] : word[11:0];
          sec = cfg_data_start + ({20'd0, cur} - 32'd2) * {24'd0, cfg_spc};
          lk.sector_index = sec;
          lk.byte_offset = sec * {19'd0, cfg_sector_bytes};
          lk.next_cluster = nxt;
          lk.last = (nxt == cfg_end_marker) || (k == MAX_RUN - 1);
          lk.truncated = (nxt != cfg_end_marker) && (k == MAX_RUN - 1);
          done = lk.last;
          cur = nxt;
        end
        walk_links[k] = lk;
        walk_len = k + 1;
      end
    end
  endtask

  // Offer one item at a falling edge and hold it until the block takes it
  task automatic send_item(input logic req, input logic [12:0] addr, input logic [7:0] data,
                           input logic [ENTRY_W-1:0] first, input logic fixed,
                           input chain_link_t fixed_link);
    int k;
    @(negedge clk);
    while ($urandom_range(99) < idle_pct) begin
      start = 1'b0;
      @(negedge clk);
    end
    start = 1'b1;
    req_type = req;
    table_address = addr;
    table_byte = data;
    start_cluster = first;
    @(posedge clk);
    while (busy) @(posedge clk);
    items_sent++;
    if (req == REQ_LOAD) begin
      tbl_image[addr] = data;
      tbl_written[addr] = 1'b1;
    end else begin
      walks_sent++;
      if (fixed) begin
        pending_links.push_back(fixed_link);
      end else begin
        trace_chain(first);
        for (k = 0; k < walk_len; k++) pending_links.push_back(walk_links[k]);
      end
    end
  endtask

  // Walk from first only if every entry on the way has been loaded
  task automatic walk_checked(input logic [ENTRY_W-1:0] first);
    logic [ENTRY_W-1:0] pick;
    trace_chain(first);
    pick = walk_mapped ? first : cfg_end_marker;
    send_item(REQ_WALK, 13'($urandom), 8'($urandom), pick, 1'b0, NO_LINK);
  endtask

  // Read-modify-write of one packed 12-bit entry: two byte loads; unloaded bytes start at zero
  task automatic set_entry(input logic [ENTRY_W-1:0] id, input logic [ENTRY_W-1:0] val);
    logic [12:0] pos;
    logic [7:0]  b0;
    logic [7:0]  b1;
    pos = {1'b0, id} + {2'b00, id[11:1]};
    b0 = tbl_written[pos] ? tbl_image[pos] : 8'h00;
    b1 = tbl_written[pos + 13'd1] ? tbl_image[pos + 13'd1] : 8'h00;
    if (id[0]) begin
      b0 = {val[3:0], b0[3:0]};
      b1 = val[11:4];
    end else begin
      b0 = val[7:0];
      b1 = {b1[7:4], val[11:8]};
    end
    send_item(REQ_LOAD, pos, b0, 12'($urandom), 1'b0, NO_LINK);
    send_item(REQ_LOAD, pos + 13'd1, b1, 12'($urandom), 1'b0, NO_LINK);
  endtask

  // Lay down a fresh chain of distinct clusters, then walk it from its head
  task automatic build_and_walk();
    logic [ENTRY_W-1:0] ids [20];
    logic [ENTRY_W-1:0] cand;
    logic [ENTRY_W-1:0] tail;
    int                 len;
    int                 i;
    int                 j;
    int                 pick;
    bit                 clash;
    len = ($urandom_range(9) == 0) ? $urandom_range(7, 20) : $urandom_range(1, 6);
    for (i = 0; i < len; i++) begin
      do begin
        cand = 12'($urandom_range(2, 4095));
        clash = (cand == cfg_end_marker);
        for (j = 0; j < i; j++) if (ids[j] == cand) clash = 1'b1;
      end while (clash);
      ids[i] = cand;
      known_ids.push_back(cand);
    end
    // mostly a proper end, sometimes a bad id, sometimes a loop back to the head
    pick = $urandom_range(9);
    if (pick < 8) begin
      tail = cfg_end_marker;
    end else if (pick == 8) begin
      tail = (cfg_end_marker == 12'd0) ? 12'd1 :
             (cfg_end_marker == 12'd1) ? 12'd0 : 12'($urandom_range(1));
    end else begin
      tail = ids[0];
    end
    for (i = 0; i < len; i++) set_entry(ids[i], (i == len - 1) ? tail : ids[i + 1]);
    walk_checked(ids[0]);
  endtask

  // Hold the sender back until every predicted element has come and the block is idle
  task automatic drain(input int quiet);
    @(negedge clk);
    start = 1'b0;
    while (pending_links.size() != 0 || busy) @(posedge clk);
    repeat (quiet) @(posedge clk);
  endtask

  // APB write: setup cycle, access cycle, register taken when pready is high
  task automatic write_reg(input cfg_reg_t r, input logic [31:0] v);
    @(negedge clk);
    start = 1'b0;
    psel = 1'b1;
    penable = 1'b0;
    pwrite = 1'b1;
    paddr = {r, 2'b00};
    pwdata = v;
    @(negedge clk);
    penable = 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    case (r)
      REG_DATA_START:   cfg_data_start = v;
      REG_SPC:          cfg_spc = v[7:0];
      REG_SECTOR_BYTES: cfg_sector_bytes = v[12:0];
      REG_END_MARKER:   cfg_end_marker = v[ENTRY_W-1:0];
      default: ;
    endcase
    @(negedge clk);
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
  endtask

  task automatic apply_geometry(input logic [31:0] ds, input logic [31:0] spc,
                                input logic [31:0] sb, input logic [31:0] em);
    drain(QUIET_CYCLES);
    write_reg(REG_DATA_START, ds);
    write_reg(REG_SPC, spc);
    write_reg(REG_SECTOR_BYTES, sb);
    write_reg(REG_END_MARKER, em);
    settings_used++;
  endtask

  // Mostly chains built then walked; the rest revisits, noise loads and odd starts
  task automatic random_phase(input int n_items);
    int target;
    int pick;
    target = items_sent + n_items;
    while (items_sent < target) begin
      if ($urandom_range(29) == 0) drain(0);
      pick = $urandom_range(99);
      if (pick < 55) begin
        build_and_walk();
      end else if (pick < 75) begin
        if (known_ids.size() == 0) walk_checked(12'($urandom));
        else walk_checked(known_ids[$urandom_range(known_ids.size() - 1)]);
      end else if (pick < 85) begin
        send_item(REQ_LOAD, 13'($urandom_range(TABLE_BYTES - 1)), 8'($urandom),
                  12'($urandom), 1'b0, NO_LINK);
      end else if (pick < 95) begin
        walk_checked(12'($urandom));
      end else begin
        pick = $urandom_range(2);
        walk_checked(pick == 2 ? cfg_end_marker : 12'(pick));
      end
    end
  endtask

  task automatic check_field(input string name, input logic [31:0] want,
                             input logic [31:0] got);
    if (want !== got) begin
      $error("%s: expected 0x%0h, got 0x%0h", name, want, got);
      fail_count++;
    end
  endtask

  // Result monitor: each strobed element against the oldest prediction
  always @(posedge clk) begin
    chain_link_t got;
    chain_link_t want;
    if (!rst && result_valid) begin
      got = {link_id, sector_index, byte_offset, run_index, next_cluster,
             last, chain_empty, bad_cluster, truncated};
      results_seen++;
      trunc_seen += int'(got.truncated);
      bad_seen += int'(got.bad_cluster);
      empty_seen += int'(got.chain_empty);
      if (pending_links.size() == 0) begin
        $error("unexpected item: link_id 0x%0h run_index %0d", got.link_id, got.run_index);
        fail_count++;
      end else begin
        want = pending_links.pop_front();
        check_field("link_id", 32'(want.link_id), 32'(got.link_id));
        check_field("sector_index", want.sector_index, got.sector_index);
        check_field("byte_offset", want.byte_offset, got.byte_offset);
        check_field("run_index", 32'(want.run_index), 32'(got.run_index));
        check_field("next_cluster", 32'(want.next_cluster), 32'(got.next_cluster));
        check_field("last", 32'(want.last), 32'(got.last));
        check_field("chain_empty", 32'(want.chain_empty), 32'(got.chain_empty));
        check_field("bad_cluster", 32'(want.bad_cluster), 32'(got.bad_cluster));
        check_field("truncated", 32'(want.truncated), 32'(got.truncated));
      end
    end
  end

  // Watchdog: cycles with no item taken, no result and no register access
  always @(posedge clk) begin
    if (rst || (start && !busy) || result_valid || (psel && penable)) begin
      stall_cycles <= 0;
    end else if (stall_cycles >= WATCHDOG_CYCLES) begin
      $display("watchdog: no progress for %0d cycles", WATCHDOG_CYCLES);
      $display("status: fail");
      $finish;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
  end

  initial begin
    int r;
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // directed rows under reset geometry
    for (r = 0; r < 21; r++) begin
      send_item(DIRECTED[r].req, DIRECTED[r].addr, DIRECTED[r].data, DIRECTED[r].first,
                DIRECTED[r].fixed, DIRECTED[r].link);
    end

    // top extremes, offsets wrap
    apply_geometry(32'hFFFF_FFFF, 32'd128, 32'd4096, 32'hFFF);
    random_phase(40);

    idle_pct = 75;
    apply_geometry($urandom, $urandom_range(1, 128), $urandom_range(1, 4096),
                   $urandom_range(2, 4094));
    random_phase(40);

    // low extremes, end marker below 2
    idle_pct = 0;
    apply_geometry(32'd0, 32'd1, 32'd1, 32'd1);
    random_phase(40);

    // out-of-range geometry used as given
    apply_geometry($urandom, 32'd0, 32'd8191, 32'd0);
    random_phase(40);

    drain(QUIET_CYCLES);
    $display("%0d items sent, %0d of them walks, under %0d register settings",
             items_sent, walks_sent, settings_used);
    $display("%0d elements checked: %0d run-limit stops, %0d bad ids, %0d empty chains",
             results_seen, trunc_seen, bad_seen, empty_seen);
    if (fail_count == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule
